// ===== design/complex_arithmetic_unit_assert.svh =====
// assertion macros for the complex arithmetic unit
// used by the top level only; expects clk and rst in scope
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication
`define CAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CAU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/cau_pkg.sv =====
// shared request codes and flag bundle of the complex arithmetic unit
// no dependencies
`timescale 1ns / 1ps
package cau_pkg;
  localparam int REQ_W = 3;
  localparam logic [REQ_W-1:0] REQ_ADD = 3'd0;
  localparam logic [REQ_W-1:0] REQ_SUB = 3'd1;
  localparam logic [REQ_W-1:0] REQ_MUL = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DIV = 3'd3;
  localparam logic [REQ_W-1:0] REQ_MAG = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CMP = 3'd5;

  typedef struct packed {
    logic is_div;
    logic ovf_re;
    logic ovf_im;
    logic neg_re;
    logic neg_im;
    logic greater;
    logic less;
    logic equal;
    logic a_zero;
    logic div_zero;
    logic sat;
  } flags_t;
endpackage

// ===== design/cau_front.sv =====
// front end: products, sums, compare and pre-clipped results, three stages
// depends on cau_pkg
`timescale 1ns / 1ps
module cau_front import cau_pkg::*; #(
  parameter int W = 16,
  parameter int F = 8
) (
  input  logic                  clk,
  input  logic [2:0]            en,
  input  logic [REQ_W-1:0]      req_type,
  input  logic signed [W-1:0]   a_re,
  input  logic signed [W-1:0]   a_im,
  input  logic signed [W-1:0]   b_re,
  input  logic signed [W-1:0]   b_im,
  output flags_t                flags,
  output logic [W-1:0]          pre_re,
  output logic [W-1:0]          pre_im,
  output logic [3*W+F:0]        rem_re,
  output logic [3*W+F:0]        rem_im,
  output logic [W-1:0]          q_re,
  output logic [W-1:0]          q_im,
  output logic [2*W-1:0]        den,
  output logic [2*W-1:0]        x,
  output logic [W-1:0]          root
);
  localparam int PW2 = 2 * W;
  localparam int RW = 3 * W + F + 1;
  localparam logic [W-1:0] P_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] P_MIN = {1'b1, {(W-1){1'b0}}};

  // stage 1
  logic [REQ_W-1:0] op1;
  logic signed [PW2-1:0] p_rr, p_ii, p_ri, p_ir, p_ar, p_ai, p_br, p_bi;
  logic signed [W:0] s_re1, s_im1;
  logic az1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      op1 <= req_type;
      p_rr <= a_re * b_re;
      p_ii <= a_im * b_im;
      p_ri <= a_re * b_im;
      p_ir <= a_im * b_re;
      p_ar <= a_re * a_re;
      p_ai <= a_im * a_im;
      p_br <= b_re * b_re;
      p_bi <= b_im * b_im;
      if (req_type == REQ_SUB) begin
        s_re1 <= a_re - b_re;
        s_im1 <= a_im - b_im;
      end else begin
        s_re1 <= a_re + b_re;
        s_im1 <= a_im + b_im;
      end
      az1 <= (a_re == '0) && (a_im == '0);
    end
  end

  // stage 2
  logic [REQ_W-1:0] op2;
  logic [PW2-1:0] sq_a2, sq_b2;
  logic signed [PW2:0] n_re2, n_im2;
  logic signed [W:0] s_re2, s_im2;
  logic az2;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      op2 <= op1;
      sq_a2 <= $unsigned(p_ar) + $unsigned(p_ai);
      sq_b2 <= $unsigned(p_br) + $unsigned(p_bi);
      if (op1 == REQ_MUL) begin
        n_re2 <= p_rr - p_ii;
        n_im2 <= p_ri + p_ir;
      end else begin
        n_re2 <= p_rr + p_ii;
        n_im2 <= p_ir - p_ri;
      end
      s_re2 <= s_re1;
      s_im2 <= s_im1;
      az2 <= az1;
    end
  end

  // stage 3 logic
  logic [PW2:0] mag_re, mag_im;
  logic [RW-1:0] num_re, num_im, den_w;
  logic signed [PW2:0] sh_re, sh_im;
  logic [W-1:0] v_re, v_im;
  logic sat_re, sat_im, dz, is_div;
  flags_t fl;

  always_comb begin
    mag_re = n_re2[PW2] ? $unsigned(-n_re2) : $unsigned(n_re2);
    mag_im = n_im2[PW2] ? $unsigned(-n_im2) : $unsigned(n_im2);
    num_re = RW'(mag_re) << F;
    num_im = RW'(mag_im) << F;
    den_w = RW'(sq_b2) << W;
    sh_re = n_re2 >>> F;
    sh_im = n_im2 >>> F;
    dz = (op2 == REQ_DIV) && (sq_b2 == '0);
    is_div = (op2 == REQ_DIV) && (sq_b2 != '0);
    v_re = '0;
    v_im = '0;
    sat_re = 1'b0;
    sat_im = 1'b0;
    case (op2)
      REQ_ADD, REQ_SUB: begin
        sat_re = s_re2[W] != s_re2[W-1];
        sat_im = s_im2[W] != s_im2[W-1];
        v_re = sat_re ? (s_re2[W] ? P_MIN : P_MAX) : s_re2[W-1:0];
        v_im = sat_im ? (s_im2[W] ? P_MIN : P_MAX) : s_im2[W-1:0];
      end
      REQ_MUL: begin
        // upper bits must all match the sign for the value to fit
        sat_re = !((&sh_re[PW2:W-1]) || !(|sh_re[PW2:W-1]));
        sat_im = !((&sh_im[PW2:W-1]) || !(|sh_im[PW2:W-1]));
        v_re = sat_re ? (sh_re[PW2] ? P_MIN : P_MAX) : sh_re[W-1:0];
        v_im = sat_im ? (sh_im[PW2] ? P_MIN : P_MAX) : sh_im[W-1:0];
      end
      default: begin
        v_re = '0;
        v_im = '0;
      end
    endcase
    fl.is_div = is_div;
    fl.ovf_re = num_re >= den_w;
    fl.ovf_im = num_im >= den_w;
    fl.neg_re = n_re2[PW2];
    fl.neg_im = n_im2[PW2];
    fl.greater = sq_a2 > sq_b2;
    fl.less = sq_a2 < sq_b2;
    fl.equal = sq_a2 == sq_b2;
    fl.a_zero = az2;
    fl.div_zero = dz;
    fl.sat = sat_re || sat_im;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      flags <= fl;
      pre_re <= v_re;
      pre_im <= v_im;
      rem_re <= num_re;
      rem_im <= num_im;
      q_re <= '0;
      q_im <= '0;
      den <= sq_b2;
      x <= sq_a2;
      root <= '0;
    end
  end
endmodule

// ===== design/cau_iter.sv =====
// one quotient bit of both divides and one root bit of the square root
// depends on cau_pkg
`timescale 1ns / 1ps
module cau_iter import cau_pkg::*; #(
  parameter int W = 16,
  parameter int F = 8,
  parameter int BIT = 0
) (
  input  logic             clk,
  input  logic             en,
  input  flags_t           flags_i,
  input  logic [W-1:0]     pre_re_i,
  input  logic [W-1:0]     pre_im_i,
  input  logic [3*W+F:0]   rem_re_i,
  input  logic [3*W+F:0]   rem_im_i,
  input  logic [W-1:0]     q_re_i,
  input  logic [W-1:0]     q_im_i,
  input  logic [2*W-1:0]   den_i,
  input  logic [2*W-1:0]   x_i,
  input  logic [W-1:0]     root_i,
  output flags_t           flags_o,
  output logic [W-1:0]     pre_re_o,
  output logic [W-1:0]     pre_im_o,
  output logic [3*W+F:0]   rem_re_o,
  output logic [3*W+F:0]   rem_im_o,
  output logic [W-1:0]     q_re_o,
  output logic [W-1:0]     q_im_o,
  output logic [2*W-1:0]   den_o,
  output logic [2*W-1:0]   x_o,
  output logic [W-1:0]     root_o
);
  localparam int RW = 3 * W + F + 1;
  localparam int SW = 2 * W + 1;

  logic [RW-1:0] dsh;
  logic [SW-1:0] trial;
  logic take_re, take_im, take_x;

  always_comb begin
    dsh = RW'(den_i) << BIT;
    take_re = rem_re_i >= dsh;
    take_im = rem_im_i >= dsh;
    // (root + 2^bit)^2 - root^2 with the higher root bits already in place
    trial = (SW'(root_i) << (BIT + 1)) + (SW'(1) << (2 * BIT));
    take_x = SW'(x_i) >= trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags_o <= flags_i;
      pre_re_o <= pre_re_i;
      pre_im_o <= pre_im_i;
      den_o <= den_i;
      rem_re_o <= take_re ? rem_re_i - dsh : rem_re_i;
      rem_im_o <= take_im ? rem_im_i - dsh : rem_im_i;
      q_re_o <= q_re_i | (W'(take_re) << BIT);
      q_im_o <= q_im_i | (W'(take_im) << BIT);
      x_o <= take_x ? x_i - trial[2*W-1:0] : x_i;
      root_o <= root_i | (W'(take_x) << BIT);
    end
  end
endmodule

// ===== design/cau_back.sv =====
// output stage: divide rounding and clipping, result register
// depends on cau_pkg
`timescale 1ns / 1ps
module cau_back import cau_pkg::*; #(
  parameter int W = 16,
  parameter int F = 8
) (
  input  logic                clk,
  input  logic                en,
  input  flags_t              flags,
  input  logic [W-1:0]        pre_re,
  input  logic [W-1:0]        pre_im,
  input  logic [3*W+F:0]      rem_re,
  input  logic [3*W+F:0]      rem_im,
  input  logic [W-1:0]        q_re,
  input  logic [W-1:0]        q_im,
  input  logic [W-1:0]        root,
  output logic signed [W-1:0] res_re,
  output logic signed [W-1:0] res_im,
  output logic [W:0]          magnitude,
  output logic                greater,
  output logic                less,
  output logic                equal,
  output logic                a_is_zero,
  output logic                div_by_zero,
  output logic                saturated
);
  localparam logic [W-1:0] P_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] P_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W:0] N_LIM = (W+1)'(1) << (W - 1);

  logic [W:0] qq_re, qq_im, ng_re, ng_im;
  logic [W-1:0] d_re, d_im;
  logic s_re, s_im;

  always_comb begin
    // floor for negative quotients: bump the magnitude when a remainder is left
    qq_re = {1'b0, q_re} + (W+1)'(rem_re != '0);
    qq_im = {1'b0, q_im} + (W+1)'(rem_im != '0);
    ng_re = -qq_re;
    ng_im = -qq_im;
    if (flags.ovf_re) begin
      s_re = 1'b1;
      d_re = flags.neg_re ? P_MIN : P_MAX;
    end else if (!flags.neg_re) begin
      s_re = q_re[W-1];
      d_re = s_re ? P_MAX : q_re;
    end else begin
      s_re = qq_re > N_LIM;
      d_re = s_re ? P_MIN : ng_re[W-1:0];
    end
    if (flags.ovf_im) begin
      s_im = 1'b1;
      d_im = flags.neg_im ? P_MIN : P_MAX;
    end else if (!flags.neg_im) begin
      s_im = q_im[W-1];
      d_im = s_im ? P_MAX : q_im;
    end else begin
      s_im = qq_im > N_LIM;
      d_im = s_im ? P_MIN : ng_im[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (flags.is_div) begin
        res_re <= d_re;
        res_im <= d_im;
        saturated <= s_re || s_im;
      end else begin
        res_re <= pre_re;
        res_im <= pre_im;
        saturated <= flags.sat;
      end
      magnitude <= {1'b0, root};
      greater <= flags.greater;
      less <= flags.less;
      equal <= flags.equal;
      a_is_zero <= flags.a_zero;
      div_by_zero <= flags.div_zero;
    end
  end
endmodule

// ===== design/complex_arithmetic_unit.sv =====
// complex arithmetic unit: request channel in, result channel out
// usage:
//   req_valid/req_ready take one item: req_type and operands a, b in signed
//   fixed point with FRAC_BITS fraction bits and PART_WIDTH bits per part.
//   res_valid/res_ready deliver one result item per request, in order.
// stages: two product/sum stages, one prepare stage, one stage per
//   quotient and root bit, one output register.
// throughput: one item per cycle unless the output stalls; every stage has its
//   own valid bit and loads when it is empty or its contents move on, so bubbles
//   close up and req_ready stays high while the pipeline still has an empty slot.
// stall: while res_ready is low the output holds; upstream stages keep
//   filling until the pipeline is full, then req_ready drops.
// reset: rst (synchronous, active high) clears all valid bits; data
//   registers are not reset.
// results: add/sub/mul/div saturate with the saturated flag, divide by
//   zero gives zero with div_by_zero, magnitude and compare flags are
//   given for every item.
`timescale 1ns / 1ps
`include "complex_arithmetic_unit_assert.svh"
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int FRAC_BITS = 8,
  parameter int PART_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic [REQ_W-1:0]             req_type,
  input  logic signed [PART_WIDTH-1:0] a_re,
  input  logic signed [PART_WIDTH-1:0] a_im,
  input  logic signed [PART_WIDTH-1:0] b_re,
  input  logic signed [PART_WIDTH-1:0] b_im,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic signed [PART_WIDTH-1:0] res_re,
  output logic signed [PART_WIDTH-1:0] res_im,
  output logic [PART_WIDTH:0]          magnitude,
  output logic                         greater,
  output logic                         less,
  output logic                         equal,
  output logic                         a_is_zero,
  output logic                         div_by_zero,
  output logic                         saturated
);
  localparam int W = PART_WIDTH;
  localparam int F = FRAC_BITS;
  localparam int S = W + 4;
  localparam int RW = 3 * W + F + 1;

  logic [S-1:0] vld;
  logic [S-1:0] en;

  always_comb begin
    en[S-1] = !vld[S-1] || res_ready;
    for (int j = S - 2; j >= 0; j--) begin
      en[j] = !vld[j] || en[j+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= req_valid;
      for (int j = 1; j < S; j++) begin
        if (en[j]) vld[j] <= vld[j-1];
      end
    end
  end

  assign req_ready = en[0];
  assign res_valid = vld[S-1];

  flags_t fl_c [0:W];
  logic [W-1:0] pre_re_c [0:W];
  logic [W-1:0] pre_im_c [0:W];
  logic [RW-1:0] rem_re_c [0:W];
  logic [RW-1:0] rem_im_c [0:W];
  logic [W-1:0] q_re_c [0:W];
  logic [W-1:0] q_im_c [0:W];
  logic [2*W-1:0] den_c [0:W];
  logic [2*W-1:0] x_c [0:W];
  logic [W-1:0] root_c [0:W];

  cau_front #(.W(W), .F(F)) u_front (
    .clk(clk), .en(en[2:0]), .req_type(req_type),
    .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
    .flags(fl_c[0]), .pre_re(pre_re_c[0]), .pre_im(pre_im_c[0]),
    .rem_re(rem_re_c[0]), .rem_im(rem_im_c[0]),
    .q_re(q_re_c[0]), .q_im(q_im_c[0]), .den(den_c[0]),
    .x(x_c[0]), .root(root_c[0])
  );

  // stage k resolves bit W-1-k, most significant first
  for (genvar k = 0; k < W; k++) begin : g_iter
    cau_iter #(.W(W), .F(F), .BIT(W - 1 - k)) u_iter (
      .clk(clk), .en(en[3+k]),
      .flags_i(fl_c[k]), .pre_re_i(pre_re_c[k]), .pre_im_i(pre_im_c[k]),
      .rem_re_i(rem_re_c[k]), .rem_im_i(rem_im_c[k]),
      .q_re_i(q_re_c[k]), .q_im_i(q_im_c[k]), .den_i(den_c[k]),
      .x_i(x_c[k]), .root_i(root_c[k]),
      .flags_o(fl_c[k+1]), .pre_re_o(pre_re_c[k+1]), .pre_im_o(pre_im_c[k+1]),
      .rem_re_o(rem_re_c[k+1]), .rem_im_o(rem_im_c[k+1]),
      .q_re_o(q_re_c[k+1]), .q_im_o(q_im_c[k+1]), .den_o(den_c[k+1]),
      .x_o(x_c[k+1]), .root_o(root_c[k+1])
    );
  end

  cau_back #(.W(W), .F(F)) u_back (
    .clk(clk), .en(en[S-1]),
    .flags(fl_c[W]), .pre_re(pre_re_c[W]), .pre_im(pre_im_c[W]),
    .rem_re(rem_re_c[W]), .rem_im(rem_im_c[W]),
    .q_re(q_re_c[W]), .q_im(q_im_c[W]), .root(root_c[W]),
    .res_re(res_re), .res_im(res_im), .magnitude(magnitude),
    .greater(greater), .less(less), .equal(equal), .a_is_zero(a_is_zero),
    .div_by_zero(div_by_zero), .saturated(saturated)
  );

  `CAU_ASSERT_IMP(a_dz_result, res_valid && div_by_zero, (res_re == '0) && (res_im == '0) && !saturated, "divide by zero result not cleared")
  `CAU_ASSERT_IMP(a_cmp_onehot, res_valid, $onehot({greater, less, equal}), "compare flags not exclusive")
  `CAU_ASSERT_NXT(a_enter, req_valid && req_ready, vld[0], "accepted item lost at entry")
  `CAU_ASSERT_IMP(a_full_stall, !req_ready, vld[0] && res_valid && !res_ready, "entry blocked without full stall")
endmodule

// ===== tb/tb.sv =====
// testbench for the complex arithmetic unit: random and directed requests,
// scoreboard predicts every result item and checks them in order
// depends on cau_pkg and complex_arithmetic_unit
`timescale 1ns / 1ps

class cau_scoreboard;
  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic [16:0] mag;
    logic gt, lt, eq, az, dz, sat;
  } result_t;

  result_t pending[$];
  int errors = 0;

  static function logic signed [15:0] clamp(longint v, inout logic sat);
    if (v > 32767) begin
      sat = 1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      sat = 1;
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // floor division of a signed numerator by a positive denominator
  static function longint floor_div(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den != 0) && (num < 0)) q = q - 1;
    return q;
  endfunction

  static function logic [16:0] root(longint x);
    longint r;
    r = 0;
    for (int b = 16; b >= 0; b--)
      if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= x)
        r = r + (longint'(1) << b);
    return r[16:0];
  endfunction

  function void note_request(logic [2:0] op, logic signed [15:0] ar, logic signed [15:0] ai,
                             logic signed [15:0] br, logic signed [15:0] bi);
    result_t r;
    longint xr, xi, yr, yi, sa, sb;
    xr = ar; xi = ai; yr = br; yi = bi;
    sa = xr * xr + xi * xi;
    sb = yr * yr + yi * yi;
    r.re = '0; r.im = '0; r.sat = 0; r.dz = 0;
    case (op)
      cau_pkg::REQ_ADD: begin
        r.re = clamp(xr + yr, r.sat);
        r.im = clamp(xi + yi, r.sat);
      end
      cau_pkg::REQ_SUB: begin
        r.re = clamp(xr - yr, r.sat);
        r.im = clamp(xi - yi, r.sat);
      end
      cau_pkg::REQ_MUL: begin
        r.re = clamp((xr * yr - xi * yi) >>> 8, r.sat);
        r.im = clamp((xr * yi + xi * yr) >>> 8, r.sat);
      end
      cau_pkg::REQ_DIV: begin
        if (sb == 0) r.dz = 1;
        else begin
          r.re = clamp(floor_div((xr * yr + xi * yi) * 256, sb), r.sat);
          r.im = clamp(floor_div((xi * yr - xr * yi) * 256, sb), r.sat);
        end
      end
      default: ;
    endcase
    r.mag = root(sa);
    r.gt = sa > sb;
    r.lt = sa < sb;
    r.eq = sa == sb;
    r.az = (ar == 0) && (ai == 0);
    pending.push_back(r);
  endfunction

  function void check_result(logic signed [15:0] re, logic signed [15:0] im, logic [16:0] mag,
                             logic gt, logic lt, logic eq, logic az, logic dz, logic sat);
    result_t e;
    if (pending.size() == 0) begin
      $error("result item with nothing expected");
      errors++;
      return;
    end
    e = pending.pop_front();
    if (re !== e.re) begin $error("res_re exp %0d got %0d", e.re, re); errors++; end
    if (im !== e.im) begin $error("res_im exp %0d got %0d", e.im, im); errors++; end
    if (mag !== e.mag) begin $error("magnitude exp %0d got %0d", e.mag, mag); errors++; end
    if (gt !== e.gt) begin $error("greater exp %0d got %0d", e.gt, gt); errors++; end
    if (lt !== e.lt) begin $error("less exp %0d got %0d", e.lt, lt); errors++; end
    if (eq !== e.eq) begin $error("equal exp %0d got %0d", e.eq, eq); errors++; end
    if (az !== e.az) begin $error("a_is_zero exp %0d got %0d", e.az, az); errors++; end
    if (dz !== e.dz) begin $error("div_by_zero exp %0d got %0d", e.dz, dz); errors++; end
    if (sat !== e.sat) begin $error("saturated exp %0d got %0d", e.sat, sat); errors++; end
  endfunction
endclass

module tb;
  import cau_pkg::*;

  logic clk, rst;
  logic req_valid, req_ready, res_valid, res_ready;
  logic [REQ_W-1:0] req_type;
  logic signed [15:0] a_re, a_im, b_re, b_im, res_re, res_im;
  logic [16:0] magnitude;
  logic greater, less, equal, a_is_zero, div_by_zero, saturated;

  cau_scoreboard results = new();
  bit stim_done = 0;

  complex_arithmetic_unit u_dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [15:0] pick_part();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0;
      3: return 16'($urandom_range(0, 1023) - 512);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_request(logic [2:0] op, logic signed [15:0] ar, logic signed [15:0] ai,
                              logic signed [15:0] br, logic signed [15:0] bi);
    req_valid <= 1;
    req_type <= op;
    a_re <= ar; a_im <= ai; b_re <= br; b_im <= bi;
    do @(posedge clk); while (!req_ready);
    results.note_request(op, ar, ai, br, bi);
    @(negedge clk);
    repeat (pick_gap()) begin
      req_valid <= 0;
      @(negedge clk);
    end
  endtask

  // result side: random stalls, mostly short and a few long
  initial begin
    int stall;
    res_ready = 0;
    forever begin
      @(negedge clk);
      res_ready <= 1;
      @(negedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        res_ready <= 0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk)
    if (!rst && res_valid && res_ready)
      results.check_result(res_re, res_im, magnitude, greater, less, equal, a_is_zero,
                           div_by_zero, saturated);

  initial begin
    req_valid = 0; req_type = REQ_ADD;
    a_re = 0; a_im = 0; b_re = 0; b_im = 0;
    rst = 1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;
    // directed: extremes, every operation, divide by zero, unused codes
    send_request(REQ_ADD, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_request(REQ_SUB, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send_request(REQ_ADD, 16'sh0100, -16'sh0080, 16'sh0200, 16'sh0040);
    send_request(REQ_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_request(REQ_MUL, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff);
    send_request(REQ_MUL, -16'sh0001, 16'sh0001, 16'sh0001, 16'sh0001);
    send_request(REQ_DIV, 16'sh0100, 16'sh0100, 16'sh0000, 16'sh0000);
    send_request(REQ_DIV, 16'sh7fff, 16'sh7fff, 16'sh0001, 16'sh0000);
    send_request(REQ_DIV, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_request(REQ_DIV, -16'sh0001, 16'sh0000, 16'sh0300, 16'sh0000);
    send_request(REQ_MAG, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000);
    send_request(REQ_MAG, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_request(REQ_CMP, 16'sh0300, 16'sh0400, 16'sh0500, 16'sh0000);
    send_request(REQ_CMP, 16'sh0001, 16'sh0000, 16'sh0002, 16'sh0000);
    send_request(REQ_CMP, 16'sh8000, 16'sh0000, 16'sh0000, 16'sh7fff);
    send_request(3'd6, 16'sh1234, -16'sh0042, 16'sh0000, 16'sh0000);
    send_request(3'd7, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
    for (int i = 0; i < 1600; i++) begin
      logic [2:0] op;
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      if (i == 800) begin
        // let the pipeline drain completely once
        req_valid <= 0;
        while (results.pending.size() != 0) @(negedge clk);
      end
      send_request(op, pick_part(), pick_part(),
                   ($urandom_range(0, 9) == 0) ? 16'sh0 : pick_part(),
                   ($urandom_range(0, 9) == 0) ? 16'sh0 : pick_part());
    end
    req_valid <= 0;
    while (results.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (results.errors == 0 && results.pending.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
